// ===== design/bcu_pkg.sv =====
// Shared widths, command and status types for the binomial coefficient unit.
package bcu_pkg;

    localparam int N_W      = 6;
    localparam int RES_W    = 60;
    localparam int PROD_W   = RES_W + N_W;
    localparam int IDX_W    = 6;
    localparam int REM_W    = 6;
    localparam int CNT_W    = $clog2(PROD_W);
    localparam int IN_TDATA_W  = ((2 * N_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture n and k from the input transfer
        logic setup;     // fold k, resolve special cases, seed the accumulator
        logic mul;       // form r * (n + 1 - i)
        logic div;       // one restoring divide step
        logic finish;    // move the accumulator into the output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic special;   // result already final after setup
        logic loop_done; // loop index passed the folded k
        logic div_last;  // current divide step is the last one
        logic out_busy;  // output register holds a result not taken this cycle
    } t_status;

endpackage

// ===== design/bcu_ctrl.sv =====
// Sequencer for the multiply and serial divide loop.
module bcu_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  bcu_pkg::t_status  i_status,
    output bcu_pkg::t_cmd     o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_CHECK,
        ST_MUL,
        ST_DIV,
        ST_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SETUP;
                end
            end
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = ST_CHECK;
            end
            ST_CHECK: begin
                if (i_status.special || i_status.loop_done) begin
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_CHECK;
                end
            end
            ST_FINISH: begin
                // hold until the output register is free
                if (!i_status.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule

// ===== design/bcu_dp.sv =====
// Datapath: operand registers, 60x6 multiplier, restoring divider, output register.
module bcu_dp #(
    parameter int MAX_N = 63
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [bcu_pkg::N_W-1:0]      i_n_total,
    input  logic [bcu_pkg::N_W-1:0]      i_k_chosen,
    input  bcu_pkg::t_cmd                i_cmd,
    output bcu_pkg::t_status             o_status,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [bcu_pkg::RES_W-1:0]    o_coefficient
);

    localparam logic [bcu_pkg::N_W-1:0] MaxN = bcu_pkg::N_W'(MAX_N);

    logic [bcu_pkg::N_W-1:0]    r_n;
    logic [bcu_pkg::N_W-1:0]    r_k;
    logic [bcu_pkg::N_W-1:0]    r_kk;
    logic [bcu_pkg::IDX_W-1:0]  r_i;
    logic                       r_special;
    logic [bcu_pkg::RES_W-1:0]  r_acc;
    logic [bcu_pkg::PROD_W-1:0] r_prod;
    logic [bcu_pkg::REM_W-1:0]  r_rem;
    logic [bcu_pkg::CNT_W-1:0]  r_cnt;
    logic [bcu_pkg::RES_W-1:0]  r_out;
    logic                       r_out_valid;

    logic                       w_bad;
    logic [bcu_pkg::N_W-1:0]    w_kk;
    logic [bcu_pkg::N_W-1:0]    w_m;
    logic [bcu_pkg::N_W:0]      w_m_full;
    logic [bcu_pkg::PROD_W-1:0] w_prod;
    logic [bcu_pkg::REM_W:0]    w_shift;
    logic [bcu_pkg::REM_W:0]    w_div;
    logic                       w_qbit;

    // fold k onto the smaller half and flag the cases that need no loop
    assign w_bad = (r_n > MaxN) || (r_k > r_n);
    assign w_kk  = (r_k > (r_n >> 1)) ? (r_n - r_k) : r_k;

    // next factor n + 1 - i, never below one inside the loop
    assign w_m_full = {1'b0, r_n} + (bcu_pkg::N_W+1)'(1) - {1'b0, r_i};
    assign w_m      = w_m_full[bcu_pkg::N_W-1:0];
    assign w_prod   = r_acc * w_m;

    // one restoring step: bring in the top dividend bit, try subtracting i
    assign w_shift = {r_rem, r_prod[bcu_pkg::PROD_W-1]};
    assign w_div   = (bcu_pkg::REM_W+1)'(r_i);
    assign w_qbit  = (w_shift >= w_div);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n <= i_n_total;
            r_k <= i_k_chosen;
        end
        if (i_cmd.setup) begin
            r_kk      <= w_kk;
            r_i       <= bcu_pkg::IDX_W'(2);
            r_special <= w_bad || (w_kk == '0);
            if (w_bad) begin
                r_acc <= '0;
            end else if (w_kk == '0) begin
                r_acc <= bcu_pkg::RES_W'(1);
            end else begin
                r_acc <= bcu_pkg::RES_W'(r_n);
            end
        end
        if (i_cmd.mul) begin
            r_prod <= w_prod;
            r_rem  <= '0;
            r_cnt  <= '0;
        end
        if (i_cmd.div) begin
            // dividend bits leave the top while quotient bits enter the bottom
            r_prod <= {r_prod[bcu_pkg::PROD_W-2:0], w_qbit};
            if (w_qbit) begin
                r_rem <= bcu_pkg::REM_W'(w_shift - w_div);
            end else begin
                r_rem <= w_shift[bcu_pkg::REM_W-1:0];
            end
            r_cnt <= r_cnt + bcu_pkg::CNT_W'(1);
            if (o_status.div_last) begin
                r_acc <= {r_prod[bcu_pkg::RES_W-2:0], w_qbit};
                r_i   <= r_i + bcu_pkg::IDX_W'(1);
            end
        end
        if (i_cmd.finish) begin
            r_out <= r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.special   = r_special;
    assign o_status.loop_done = (r_i > r_kk);
    assign o_status.div_last  = (r_cnt == bcu_pkg::CNT_W'(bcu_pkg::PROD_W - 1));
    assign o_status.out_busy  = r_out_valid && !i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_coefficient = r_out;

endmodule

// ===== design/binomial_coefficient_unit.sv =====
// Top level of the binomial coefficient unit.
//
// Each input transfer carries n and k (0 to 63); one output transfer returns the exact
// unsigned C(n,k) in 60 bits. k is first folded to min(k, n-k); C(n,0) is 1, and the
// result is 0 when k exceeds n or n exceeds MAX_N. The value is built by the
// multiplicative rule r = n, then r = r*(n+1-i)/i for i = 2 .. k, with a registered
// 60x6 multiply into a 66-bit product and a restoring divider that retires one
// quotient bit per cycle; each loop pass runs a 66-step divide. The unit takes one
// item at a time; the next input transfer is taken as soon as the result sits in the
// output register, even while that result is still waiting to be taken.
module binomial_coefficient_unit #(
    parameter int MAX_N = 63
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [5:0] n_total, [11:6] k_chosen, [15:12] zero
    input  logic [bcu_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [59:0] coefficient, [63:60] zero
    output logic [bcu_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    bcu_pkg::t_cmd              w_cmd;
    bcu_pkg::t_status           w_status;
    logic [bcu_pkg::RES_W-1:0]  w_coefficient;

    // sequencer: accept, setup, loop of multiply and divide, hand off to output
    bcu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // arithmetic and the output register that decouples the result side
    bcu_dp #(
        .MAX_N (MAX_N)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_n_total     (s_axis_tdata[bcu_pkg::N_W-1:0]),
        .i_k_chosen    (s_axis_tdata[2*bcu_pkg::N_W-1:bcu_pkg::N_W]),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_coefficient (w_coefficient)
    );

    // pad the result up to whole bytes
    assign m_axis_tdata = bcu_pkg::OUT_TDATA_W'(w_coefficient);

`ifndef SYNTHESIS
    // an accepted item keeps the input closed while it is worked on
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input reopened right after a transfer");

    // a new result only appears when the sequencer was busy the cycle before
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared without work in progress");

    // a result is loaded only when the previous one has gone
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("pending result overwritten");
`endif

endmodule
